// ----- src/bldc_hc_pkg.sv -----
// Shared types, codes and commutation tables for the two-motor hall commutation unit.
// Used by bldc_hc_scale, bldc_hc_commutate and bldc_hall_commutation_unit.
`default_nettype none

package bldc_hc_pkg;

  // Command codes carried in the input word's tuser.
  localparam logic [2:0] FUNC_HALL    = 3'd0;
  localparam logic [2:0] FUNC_DUTY    = 3'd1;
  localparam logic [2:0] FUNC_DISABLE = 3'd2;
  localparam logic [2:0] FUNC_ENABLE  = 3'd3;
  localparam logic [2:0] FUNC_INIT    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PERIOD_TICKS = 2'd0;
  localparam logic [1:0] CFG_PWM_MAX      = 2'd1;
  localparam logic [1:0] CFG_PWM_MIN      = 2'd2;

  localparam logic [9:0] PERIOD_TICKS_RESET = 10'd400;
  localparam logic [9:0] PWM_MAX_RESET      = 10'd399;
  localparam logic [9:0] PWM_MIN_RESET      = 10'd1;

  // Phase indexes.
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  // Levels and enables of one motor's three phases.
  typedef struct packed {
    logic [10:0] a;
    logic [10:0] b;
    logic [9:0]  c;
    logic [2:0]  en;
  } phase_out_t;

  // Forward high-side phase for each hall code.
  function automatic logic [1:0] hi_phase(input logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      3'd1:    p = PH_A;
      3'd2:    p = PH_B;
      3'd3:    p = PH_B;
      3'd4:    p = PH_C;
      3'd5:    p = PH_A;
      3'd6:    p = PH_C;
      default: p = PH_A;
    endcase
    return p;
  endfunction

  // Forward low-side phase for each hall code.
  function automatic logic [1:0] lo_phase(input logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      3'd1:    p = PH_C;
      3'd2:    p = PH_A;
      3'd3:    p = PH_C;
      3'd4:    p = PH_B;
      3'd5:    p = PH_B;
      3'd6:    p = PH_A;
      default: p = PH_A;
    endcase
    return p;
  endfunction

  // Hall code that precedes the given code in forward rotation.
  function automatic logic [2:0] fwd_prev(input logic [2:0] code);
    logic [2:0] p;
    unique case (code)
      3'd1:    p = 3'd3;
      3'd2:    p = 3'd6;
      3'd3:    p = 3'd2;
      3'd4:    p = 3'd5;
      3'd5:    p = 3'd1;
      3'd6:    p = 3'd4;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  // Step counter update for one hall transition.
  function automatic logic [15:0] count_step(input logic [15:0] cnt,
                                             input logic [2:0]  old_code,
                                             input logic [2:0]  new_code);
    logic [15:0] r;
    if (new_code == old_code || new_code == 3'd0 || new_code == 3'd7) begin
      r = cnt;
    end else if (fwd_prev(new_code) == old_code) begin
      r = cnt + 16'd1;
    end else begin
      r = cnt - 16'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/bldc_hc_scale.sv -----
// Duty scaling: takes a signed Q1.15 duty to a capped pwm magnitude.
// Depends on bldc_hc_pkg.
`default_nettype none

module bldc_hc_scale
  import bldc_hc_pkg::*;
(
  input  wire logic signed [15:0] duty,
  input  wire logic        [9:0]  period_ticks,
  input  wire logic        [9:0]  pwm_max,
  output logic             [9:0]  magnitude
);

  logic [15:0] raw;
  logic [15:0] abs_duty;
  logic [25:0] product;
  logic [10:0] scaled;

  assign raw      = duty;
  // The most negative duty wraps to 0x8000, which is its true size.
  assign abs_duty = raw[15] ? (~raw + 16'd1) : raw;
  assign product  = {10'd0, abs_duty} * {16'd0, period_ticks};
  assign scaled   = product[25:15];

  always_comb begin
    if (scaled > {1'b0, pwm_max}) begin
      magnitude = pwm_max;
    end else begin
      magnitude = scaled[9:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/bldc_hc_commutate.sv -----
// Six-step commutation of one motor: phase levels and driver enables from the hall code.
// Depends on bldc_hc_pkg.
`default_nettype none

module bldc_hc_commutate
  import bldc_hc_pkg::*;
(
  input  wire logic       drive,
  input  wire logic [2:0] code,
  input  wire logic       forward,
  input  wire logic [9:0] magnitude,
  input  wire logic [9:0] pwm_min,
  input  wire logic       double_ab,
  output phase_out_t      phases
);

  logic [1:0]  hi;
  logic [1:0]  lo;
  logic [10:0] hi_level;
  logic [10:0] lo_level;
  logic        active;

  assign active   = drive && (code != 3'd0) && (code != 3'd7);
  // Reverse rotation swaps the high and low phases.
  assign hi       = forward ? hi_phase(code) : lo_phase(code);
  assign lo       = forward ? lo_phase(code) : hi_phase(code);
  assign hi_level = (double_ab && hi != PH_C) ? {magnitude, 1'b0} : {1'b0, magnitude};
  assign lo_level = {1'b0, pwm_min};

  always_comb begin
    phases = '0;
    if (active) begin
      if (hi == PH_A) begin
        phases.a = hi_level;
      end else if (lo == PH_A) begin
        phases.a = lo_level;
      end
      if (hi == PH_B) begin
        phases.b = hi_level;
      end else if (lo == PH_B) begin
        phases.b = lo_level;
      end
      if (hi == PH_C) begin
        phases.c = hi_level[9:0];
      end else if (lo == PH_C) begin
        phases.c = lo_level[9:0];
      end
      phases.en[0] = (hi == PH_A) || (lo == PH_A);
      phases.en[1] = (hi == PH_B) || (lo == PH_B);
      phases.en[2] = (hi == PH_C) || (lo == PH_C);
    end
  end

endmodule

`default_nettype wire

// ----- src/bldc_hall_commutation_unit.sv -----
// Top level of the two-motor six-step hall commutation unit.
// Depends on bldc_hc_pkg, bldc_hc_scale and bldc_hc_commutate.
`default_nettype none

// Each input word carries a command (hall update, set duty, disable, enable or init) together
// with both motors' hall codes and signed Q1.15 duties, and produces exactly one output word
// holding the six phase compare levels, the six driver enables and both wrapping hall step
// counts as they stand after the command. The block accepts one word per clock cycle while the
// output side does not stall: an accepted word sits in an input register, then a single pass
// of logic (a 16 by 10 bit multiply with its cap for each motor's duty, the commutation table
// and the counter step) updates the motor state and loads the result register, from which
// the result is presented. Both registers hold while the output side stalls: the input
// register can still take one word behind a waiting result, after which the input is not
// ready until the output moves. With no stall, words may arrive back to back. The pwm
// period, ceiling and low-side level are written through the configuration channel, which
// is always ready; they must only be changed while no word is in flight.
// Hall codes 0 and 7 switch every phase of that motor off. Right phases A and B carry a
// doubled high-side level in 11-bit fields; the other channels carry 10-bit levels.
module bldc_hall_commutation_unit
  import bldc_hc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,

  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [2:0] hall_right, [5:3] hall_left, [21:6] duty_right, [37:22] duty_left, rest zero
  input  wire logic [39:0]  s_axis_tdata,
  // [2:0] func
  input  wire logic [2:0]   s_axis_tuser,

  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [10:0] right_a_level, [21:11] right_b_level, [31:22] right_c_level,
  // [41:32] left_a_level, [51:42] left_b_level, [61:52] left_c_level,
  // [67:62] driver_enables, [83:68] right_ticks, [99:84] left_ticks, rest zero
  output logic [103:0]      m_axis_tdata,

  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [9:0]   cfg_data
);

  // Configuration registers.
  logic [9:0] period_ticks;
  logic [9:0] pwm_max;
  logic [9:0] pwm_min;

  // Input register.
  logic              in_valid;
  logic [2:0]        in_func;
  logic [2:0]        in_hall_right;
  logic [2:0]        in_hall_left;
  logic signed [15:0] in_duty_right;
  logic signed [15:0] in_duty_left;

  // Motor state.
  logic [2:0]  right_hall_code;
  logic [2:0]  left_hall_code;
  logic [9:0]  right_magnitude;
  logic [9:0]  left_magnitude;
  logic        right_forward;
  logic        left_forward;
  logic [15:0] right_count;
  logic [15:0] left_count;

  logic [2:0]  right_hall_code_next;
  logic [2:0]  left_hall_code_next;
  logic [9:0]  right_magnitude_next;
  logic [9:0]  left_magnitude_next;
  logic        right_forward_next;
  logic        left_forward_next;
  logic [15:0] right_count_next;
  logic [15:0] left_count_next;

  logic        drive;
  logic        enable_all;
  logic [9:0]  right_scaled;
  logic [9:0]  left_scaled;
  phase_out_t  right_phases;
  phase_out_t  left_phases;
  logic [5:0]  enables;
  logic [103:0] result;

  // Result register.
  logic         out_valid;
  logic [103:0] out_word;

  logic fire;

  // The input register advances whenever the result register is free or being emptied.
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_TICKS_RESET;
      pwm_max      <= PWM_MAX_RESET;
      pwm_min      <= PWM_MIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PERIOD_TICKS: period_ticks <= cfg_data;
        CFG_PWM_MAX:      pwm_max      <= cfg_data;
        CFG_PWM_MIN:      pwm_min      <= cfg_data;
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func       <= s_axis_tuser;
      in_hall_right <= s_axis_tdata[2:0];
      in_hall_left  <= s_axis_tdata[5:3];
      in_duty_right <= s_axis_tdata[21:6];
      in_duty_left  <= s_axis_tdata[37:22];
    end
  end

  bldc_hc_scale u_scale_right (
    .duty         (in_duty_right),
    .period_ticks (period_ticks),
    .pwm_max      (pwm_max),
    .magnitude    (right_scaled)
  );

  bldc_hc_scale u_scale_left (
    .duty         (in_duty_left),
    .period_ticks (period_ticks),
    .pwm_max      (pwm_max),
    .magnitude    (left_scaled)
  );

  // Next motor state for the word in the input register. Commutation below is driven from
  // these values, so a hall update uses the new codes and a duty command the new magnitudes.
  always_comb begin
    right_hall_code_next = right_hall_code;
    left_hall_code_next  = left_hall_code;
    right_magnitude_next = right_magnitude;
    left_magnitude_next  = left_magnitude;
    right_forward_next   = right_forward;
    left_forward_next    = left_forward;
    right_count_next     = right_count;
    left_count_next      = left_count;
    drive                = 1'b0;
    enable_all           = 1'b0;
    unique case (in_func)
      FUNC_HALL: begin
        right_count_next     = count_step(right_count, right_hall_code, in_hall_right);
        left_count_next      = count_step(left_count, left_hall_code, in_hall_left);
        right_hall_code_next = in_hall_right;
        left_hall_code_next  = in_hall_left;
        drive                = 1'b1;
      end
      FUNC_DUTY: begin
        right_magnitude_next = right_scaled;
        left_magnitude_next  = left_scaled;
        // The right motor is mounted mirrored, so its forward sense is a negative duty.
        right_forward_next   = in_duty_right[15];
        left_forward_next    = !in_duty_left[15];
        drive                = 1'b1;
      end
      FUNC_ENABLE: begin
        enable_all = 1'b1;
      end
      FUNC_INIT: begin
        right_hall_code_next = in_hall_right;
        left_hall_code_next  = in_hall_left;
        right_magnitude_next = '0;
        left_magnitude_next  = '0;
        right_forward_next   = 1'b0;
        left_forward_next    = 1'b0;
      end
      default: begin
        // Disable and unused codes leave the state alone and switch everything off.
      end
    endcase
  end

  bldc_hc_commutate u_comm_right (
    .drive     (drive),
    .code      (right_hall_code_next),
    .forward   (right_forward_next),
    .magnitude (right_magnitude_next),
    .pwm_min   (pwm_min),
    .double_ab (1'b1),
    .phases    (right_phases)
  );

  bldc_hc_commutate u_comm_left (
    .drive     (drive),
    .code      (left_hall_code_next),
    .forward   (left_forward_next),
    .magnitude (left_magnitude_next),
    .pwm_min   (pwm_min),
    .double_ab (1'b0),
    .phases    (left_phases)
  );

  assign enables = enable_all ? 6'h3F : {left_phases.en, right_phases.en};

  assign result = {4'd0,
                   left_count_next,
                   right_count_next,
                   enables,
                   left_phases.c,
                   left_phases.b[9:0],
                   left_phases.a[9:0],
                   right_phases.c,
                   right_phases.b,
                   right_phases.a};

  always_ff @(posedge clk) begin
    if (rst) begin
      right_hall_code <= '0;
      left_hall_code  <= '0;
      right_magnitude <= '0;
      left_magnitude  <= '0;
      right_forward   <= 1'b0;
      left_forward    <= 1'b0;
      right_count     <= '0;
      left_count      <= '0;
    end else if (fire) begin
      right_hall_code <= right_hall_code_next;
      left_hall_code  <= left_hall_code_next;
      right_magnitude <= right_magnitude_next;
      left_magnitude  <= left_magnitude_next;
      right_forward   <= right_forward_next;
      left_forward    <= left_forward_next;
      right_count     <= right_count_next;
      left_count      <= left_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result;
    end
  end

endmodule

`default_nettype wire
